>>> hw/rtl/glr_pkg.sv
// Shared types and constants for the gradient line rasterizer.
`default_nettype none

package glr_pkg;

    localparam int COORD_W    = 12;
    localparam int DELTA_W    = 8;
    localparam int COLOR_W    = 24;
    localparam int CHAN_W     = 8;
    localparam int INDEX_W    = 7;
    localparam int ERR_W      = 9;
    localparam int SPAN_W     = DELTA_W + 1;
    localparam int DIVISOR_W  = 7;
    localparam int DIVIDEND_W = CHAN_W + INDEX_W;
    localparam int CH_W       = 2;

    localparam int DEFAULT_MAX_SPAN   = 64;
    localparam int DEFAULT_COORD_BITS = 12;
    localparam int RESULT_CAP         = 64;

    localparam logic [CH_W-1:0] CH_RED   = 2'd0;
    localparam logic [CH_W-1:0] CH_GREEN = 2'd1;
    localparam logic [CH_W-1:0] CH_BLUE  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PIXEL,
        ST_MUL,
        ST_DIV,
        ST_LOAD
    } state_t;

    typedef enum logic [1:0] {
        MODE_ZERO,
        MODE_HORIZ,
        MODE_VERT,
        MODE_DIAG
    } mode_t;

endpackage

`default_nettype wire

>>> hw/rtl/glr_divider.sv
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module glr_divider
    import glr_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [DIVISOR_W-1:0]  divisor,
    output logic                       done,
    output logic [DIVIDEND_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIVIDEND_W - 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quot_reg, quot_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;
    logic [DIVISOR_W:0]    trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, quot_reg[DIVIDEND_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quot_next = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            // shift in one dividend bit, subtract when it fits
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next  = DIVISOR_W'(trial - {1'b0, dvs_reg});
                quot_next = {quot_reg[DIVIDEND_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial[DIVISOR_W-1:0];
                quot_next = {quot_reg[DIVIDEND_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        dvs_reg  <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

`default_nettype wire

>>> hw/rtl/gradient_line_rasterizer.sv
// Top level of the gradient line rasterizer: line walker, sequencer and output register.
//
// Usage: one word on the input channel (in_valid / in_stall) is one line command:
// start point, signed delta and start and end colour. The block emits the line's
// pixels in drawing order on the output channel (out_valid / out_stall), one word
// per pixel with its coordinates and colour; last marks the final pixel of the line.
// A command whose |dx|+|dy| exceeds MAX_SPAN gives a single word with span_error
// and last set and zero pixel fields. The end point itself is not drawn, unless the
// line has zero length: then its start point is the single pixel. Throughput: one
// command at a time; in_stall is high from acceptance until the last word has been
// loaded into the output register. For each pixel the sequencer steps the walker,
// then the three colour channels go one after another through a single shared
// restoring divider, each started with the channel product, and then the output
// register is loaded. A stalled output word holds; the sequencer computes the next
// pixel meanwhile and waits in its load step until the word is taken. The next
// command may be accepted while the final word still waits in the output register.
// Reset (rst_n, asynchronous, active low) empties the output register and returns
// the sequencer to idle.
`default_nettype none

module gradient_line_rasterizer
    import glr_pkg::*;
#(
    parameter int MAX_SPAN   = DEFAULT_MAX_SPAN,
    parameter int COORD_BITS = DEFAULT_COORD_BITS
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [COORD_W-1:0]        start_x,
    input  wire logic [COORD_W-1:0]        start_y,
    input  wire logic signed [DELTA_W-1:0] delta_x,
    input  wire logic signed [DELTA_W-1:0] delta_y,
    input  wire logic [COLOR_W-1:0]        color_start,
    input  wire logic [COLOR_W-1:0]        color_end,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic [COORD_W-1:0]             pixel_x,
    output logic [COORD_W-1:0]             pixel_y,
    output logic [COLOR_W-1:0]             pixel_color,
    output logic                           last,
    output logic                           span_error
);

    // positions wrap at the narrower of the coordinate space and the port width
    localparam logic [COORD_W-1:0] COORD_MASK = (COORD_BITS >= COORD_W) ? {COORD_W{1'b1}}
                                                : COORD_W'((1 << COORD_BITS) - 1);
    localparam logic [SPAN_W-1:0]  SPAN_LIMIT = SPAN_W'(MAX_SPAN);
    localparam logic [INDEX_W-1:0] CAP_INDEX  = INDEX_W'(RESULT_CAP - 1);

    state_t state_reg, state_next;

    // line walker
    mode_t                    mode_reg, mode_next;
    logic                     inner_reg, inner_next;
    logic [COORD_W-1:0]       x_reg, x_next;
    logic [COORD_W-1:0]       y_reg, y_next;
    logic signed [ERR_W-1:0]  err_reg, err_next;
    logic [INDEX_W-1:0]       i_reg, i_next;
    logic [INDEX_W-1:0]       k_reg, k_next;
    logic [DIVISOR_W-1:0]     n_reg, n_next;
    logic [DELTA_W-1:0]       adx_reg, adx_next;
    logic [DELTA_W-1:0]       ady_reg, ady_next;
    logic                     sx_neg_reg, sx_neg_next;
    logic                     sy_neg_reg, sy_neg_next;
    logic [COLOR_W-1:0]       c1_reg, c1_next;
    logic [COLOR_W-1:0]       c2_reg, c2_next;
    logic [CH_W-1:0]          ch_reg, ch_next;

    // staged pixel, waiting for the output register
    logic [COORD_W-1:0]       stg_x_reg, stg_x_next;
    logic [COORD_W-1:0]       stg_y_reg, stg_y_next;
    logic [INDEX_W-1:0]       stg_k_reg, stg_k_next;
    logic [COLOR_W-1:0]       stg_color_reg, stg_color_next;
    logic                     stg_last_reg, stg_last_next;
    logic                     stg_err_reg, stg_err_next;

    // output register
    logic                     out_valid_reg, out_valid_next;
    logic [COORD_W-1:0]       out_x_reg, out_x_next;
    logic [COORD_W-1:0]       out_y_reg, out_y_next;
    logic [COLOR_W-1:0]       out_color_reg, out_color_next;
    logic                     out_last_reg, out_last_next;
    logic                     out_err_reg, out_err_next;

    logic                     in_accept;
    logic                     slot_free;
    logic                     div_start;
    logic                     div_done;
    logic [DIVIDEND_W-1:0]    div_quot;
    logic [DIVIDEND_W-1:0]    product;

    logic [DELTA_W-1:0]       adx_in, ady_in;
    logic [SPAN_W-1:0]        span_in;
    logic [INDEX_W-1:0]       half_in;

    logic [CHAN_W-1:0]        chan_a, chan_b, chan_mag, chan_res;
    logic signed [ERR_W-1:0]  err_up, err_down;
    logic                     outer_done;

    assign in_accept = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;

    // magnitude of the deltas; -128 maps to 128, which the span check rejects
    assign adx_in  = delta_x[DELTA_W-1] ? DELTA_W'(~delta_x + 1'b1) : DELTA_W'(delta_x);
    assign ady_in  = delta_y[DELTA_W-1] ? DELTA_W'(~delta_y + 1'b1) : DELTA_W'(delta_y);
    assign span_in = {1'b0, adx_in} + {1'b0, ady_in};
    assign half_in = INDEX_W'(({1'b0, adx_in} + 1'b1) >> 1);

    // channel select for the shared divider
    always_comb
    begin
        case (ch_reg)
            CH_RED:
            begin
                chan_a = c1_reg[23:16];
                chan_b = c2_reg[23:16];
            end
            CH_GREEN:
            begin
                chan_a = c1_reg[15:8];
                chan_b = c2_reg[15:8];
            end
            default:
            begin
                chan_a = c1_reg[7:0];
                chan_b = c2_reg[7:0];
            end
        endcase
    end

    assign chan_mag = (chan_b < chan_a) ? (chan_a - chan_b) : (chan_b - chan_a);
    assign chan_res = (chan_b < chan_a) ? (chan_a - div_quot[CHAN_W-1:0])
                                        : (chan_a + div_quot[CHAN_W-1:0]);
    assign product  = DIVIDEND_W'({{INDEX_W{1'b0}}, chan_mag} * {{CHAN_W{1'b0}}, stg_k_reg});

    assign err_up     = err_reg + $signed({1'b0, ady_reg});
    assign err_down   = err_reg - $signed({1'b0, adx_reg});
    assign outer_done = ({1'b0, i_reg} + 1'b1) == adx_reg;

    glr_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (product),
        .divisor  (n_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = (span_in > SPAN_LIMIT) ? ST_LOAD : ST_PIXEL;
                end
            end
            ST_PIXEL:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = (ch_reg == CH_BLUE) ? ST_LOAD : ST_MUL;
                end
            end
            ST_LOAD:
            begin
                if (slot_free)
                begin
                    state_next = stg_last_reg ? ST_IDLE : ST_PIXEL;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_stall  = 1'b1;
        div_start = 1'b0;
        unique case (state_reg)
            ST_IDLE:  in_stall  = 1'b0;
            ST_MUL:   div_start = 1'b1;
            ST_PIXEL, ST_DIV, ST_LOAD:
            begin
                in_stall  = 1'b1;
            end
            default:
            begin
                in_stall  = 1'b1;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        mode_next      = mode_reg;
        inner_next     = inner_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        err_next       = err_reg;
        i_next         = i_reg;
        k_next         = k_reg;
        n_next         = n_reg;
        adx_next       = adx_reg;
        ady_next       = ady_reg;
        sx_neg_next    = sx_neg_reg;
        sy_neg_next    = sy_neg_reg;
        c1_next        = c1_reg;
        c2_next        = c2_reg;
        ch_next        = ch_reg;
        stg_x_next     = stg_x_reg;
        stg_y_next     = stg_y_reg;
        stg_k_next     = stg_k_reg;
        stg_color_next = stg_color_reg;
        stg_last_next  = stg_last_reg;
        stg_err_next   = stg_err_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_color_next = out_color_reg;
        out_last_next  = out_last_reg;
        out_err_next   = out_err_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    x_next      = start_x;
                    y_next      = start_y;
                    adx_next    = adx_in;
                    ady_next    = ady_in;
                    sx_neg_next = delta_x[DELTA_W-1];
                    sy_neg_next = delta_y[DELTA_W-1];
                    c1_next     = color_start;
                    c2_next     = color_end;
                    inner_next  = 1'b0;
                    i_next      = '0;
                    k_next      = '0;
                    err_next    = '0;
                    if (adx_in == '0 && ady_in == '0)
                    begin
                        mode_next = MODE_ZERO;
                        n_next    = DIVISOR_W'(1);
                    end
                    else if (ady_in == '0)
                    begin
                        mode_next = MODE_HORIZ;
                        n_next    = DIVISOR_W'(adx_in);
                    end
                    else if (adx_in == '0)
                    begin
                        mode_next = MODE_VERT;
                        n_next    = DIVISOR_W'(ady_in);
                    end
                    else
                    begin
                        mode_next = MODE_DIAG;
                        n_next    = DIVISOR_W'(span_in);
                        // floor(-adx / 2)
                        err_next  = -$signed({2'b00, half_in});
                    end
                    // rejected line: stage the error word directly
                    stg_x_next     = '0;
                    stg_y_next     = '0;
                    stg_color_next = '0;
                    stg_last_next  = 1'b1;
                    stg_err_next   = 1'b1;
                end
            end
            ST_PIXEL:
            begin
                // capture this pixel, then advance the walker to the next one
                stg_x_next   = x_reg;
                stg_y_next   = y_reg;
                stg_k_next   = k_reg;
                stg_err_next = 1'b0;
                ch_next      = CH_RED;
                k_next       = k_reg + 1'b1;
                case (mode_reg)
                    MODE_ZERO:
                    begin
                        stg_last_next = 1'b1;
                    end
                    MODE_HORIZ:
                    begin
                        x_next        = sx_neg_reg ? x_reg - 1'b1 : x_reg + 1'b1;
                        stg_last_next = (k_reg + 1'b1) == n_reg;
                    end
                    MODE_VERT:
                    begin
                        y_next        = sy_neg_reg ? y_reg - 1'b1 : y_reg + 1'b1;
                        stg_last_next = (k_reg + 1'b1) == n_reg;
                    end
                    default:
                    begin
                        if (inner_reg)
                        begin
                            err_next = err_down;
                            y_next   = sy_neg_reg ? y_reg - 1'b1 : y_reg + 1'b1;
                        end
                        else
                        begin
                            err_next = err_up;
                        end
                        if ((inner_reg ? err_down : err_up) > 0)
                        begin
                            inner_next    = 1'b1;
                            stg_last_next = 1'b0;
                        end
                        else
                        begin
                            inner_next    = 1'b0;
                            x_next        = sx_neg_reg ? x_reg - 1'b1 : x_reg + 1'b1;
                            i_next        = i_reg + 1'b1;
                            stg_last_next = outer_done;
                        end
                    end
                endcase
                // hard cap on pixels per line
                if (k_reg == CAP_INDEX)
                begin
                    stg_last_next = 1'b1;
                end
            end
            ST_MUL:
            begin
                // divider latches the channel product this cycle
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    case (ch_reg)
                        CH_RED:   stg_color_next[23:16] = chan_res;
                        CH_GREEN: stg_color_next[15:8]  = chan_res;
                        default:  stg_color_next[7:0]   = chan_res;
                    endcase
                    ch_next = ch_reg + 1'b1;
                end
            end
            ST_LOAD:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_x_next     = stg_x_reg & COORD_MASK;
                    out_y_next     = stg_y_reg & COORD_MASK;
                    out_color_next = stg_color_reg;
                    out_last_next  = stg_last_reg;
                    out_err_next   = stg_err_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        inner_reg     <= inner_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        err_reg       <= err_next;
        i_reg         <= i_next;
        k_reg         <= k_next;
        n_reg         <= n_next;
        adx_reg       <= adx_next;
        ady_reg       <= ady_next;
        sx_neg_reg    <= sx_neg_next;
        sy_neg_reg    <= sy_neg_next;
        c1_reg        <= c1_next;
        c2_reg        <= c2_next;
        ch_reg        <= ch_next;
        stg_x_reg     <= stg_x_next;
        stg_y_reg     <= stg_y_next;
        stg_k_reg     <= stg_k_next;
        stg_color_reg <= stg_color_next;
        stg_last_reg  <= stg_last_next;
        stg_err_reg   <= stg_err_next;
        out_x_reg     <= out_x_next;
        out_y_reg     <= out_y_next;
        out_color_reg <= out_color_next;
        out_last_reg  <= out_last_next;
        out_err_reg   <= out_err_next;
    end

    assign out_valid   = out_valid_reg;
    assign pixel_x     = out_x_reg;
    assign pixel_y     = out_y_reg;
    assign pixel_color = out_color_reg;
    assign last        = out_last_reg;
    assign span_error  = out_err_reg;

endmodule

`default_nettype wire

>>> tb/gradient_line_rasterizer_tb.sv
// Testbench for the gradient line rasterizer: directed and random line commands checked per pixel.
`default_nettype none

module gradient_line_rasterizer_tb
    import glr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Even with worst-case commands, heavy output stalls and sender gaps on every command,
    // a run stays well below the limit.
    localparam int CYCLE_LIMIT  = 20_000_000;
    localparam int DRAIN_CYCLES = 4000;
    localparam int RANDOM_LINES = 360;
    localparam int DIRECTED_N   = 24;

    // One line command as it goes onto the input channel.
    typedef struct packed {
        logic [COORD_W-1:0]        start_x;
        logic [COORD_W-1:0]        start_y;
        logic signed [DELTA_W-1:0] delta_x;
        logic signed [DELTA_W-1:0] delta_y;
        logic [COLOR_W-1:0]        color_start;
        logic [COLOR_W-1:0]        color_end;
    } line_cmd_t;

    // One word on the output channel.
    typedef struct packed {
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic [COLOR_W-1:0] pixel_color;
        logic               last;
        logic               span_error;
    } pixel_word_t;

    // A directed row: the command, and a single typed-in word where the answer is obvious.
    typedef struct packed {
        line_cmd_t   cmd;
        logic        typed;
        pixel_word_t want;
    } directed_row_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic [COORD_W-1:0]        start_x = '0;
    logic [COORD_W-1:0]        start_y = '0;
    logic signed [DELTA_W-1:0] delta_x = '0;
    logic signed [DELTA_W-1:0] delta_y = '0;
    logic [COLOR_W-1:0]        color_start = '0;
    logic [COLOR_W-1:0]        color_end = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [COORD_W-1:0]        pixel_x;
    logic [COORD_W-1:0]        pixel_y;
    logic [COLOR_W-1:0]        pixel_color;
    logic                      last;
    logic                      span_error;

    gradient_line_rasterizer u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .start_x     (start_x),
        .start_y     (start_y),
        .delta_x     (delta_x),
        .delta_y     (delta_y),
        .color_start (color_start),
        .color_end   (color_end),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_color (pixel_color),
        .last        (last),
        .span_error  (span_error)
    );

    // 20 ns period, high phase then low phase.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Pixels still owed by the block, oldest first.
    pixel_word_t pending_pixels[$];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          burst_left = 1;

    // Directed commands. Typed rows carry the one word they must produce: zero length,
    // single-pixel lines (start colour at index 0) and rejected spans. The rest go through
    // the gradient predictor.
    directed_row_t directed_rows [DIRECTED_N] = '{
        // zero length at both corners of the coordinate range
        '{'{12'd0, 12'd0, 8'sd0, 8'sd0, 24'h000000, 24'hFFFFFF}, 1'b1,
          '{12'd0, 12'd0, 24'h000000, 1'b1, 1'b0}},
        '{'{12'd4095, 12'd4095, 8'sd0, 8'sd0, 24'hFFFFFF, 24'h000000}, 1'b1,
          '{12'd4095, 12'd4095, 24'hFFFFFF, 1'b1, 1'b0}},
        // spans just over the limit and deltas outside the nominal range
        '{'{12'd100, 12'd200, 8'sd64, 8'sd1, 24'h123456, 24'h654321}, 1'b1,
          '{12'd0, 12'd0, 24'h000000, 1'b1, 1'b1}},
        '{'{12'd7, 12'd9, 8'sd33, -8'sd32, 24'hABCDEF, 24'h010203}, 1'b1,
          '{12'd0, 12'd0, 24'h000000, 1'b1, 1'b1}},
        '{'{12'd4095, 12'd0, -8'sd128, -8'sd128, 24'hFFFFFF, 24'hFFFFFF}, 1'b1,
          '{12'd0, 12'd0, 24'h000000, 1'b1, 1'b1}},
        '{'{12'd0, 12'd4095, 8'sd127, 8'sd0, 24'h000000, 24'h000000}, 1'b1,
          '{12'd0, 12'd0, 24'h000000, 1'b1, 1'b1}},
        '{'{12'd2048, 12'd2048, 8'sd0, -8'sd65, 24'h00FF00, 24'hFF00FF}, 1'b1,
          '{12'd0, 12'd0, 24'h000000, 1'b1, 1'b1}},
        // single-pixel axis lines
        '{'{12'd1234, 12'd3210, 8'sd1, 8'sd0, 24'h808080, 24'h7F7F7F}, 1'b1,
          '{12'd1234, 12'd3210, 24'h808080, 1'b1, 1'b0}},
        '{'{12'd55, 12'd4000, 8'sd0, -8'sd1, 24'hFEDCBA, 24'h000000}, 1'b1,
          '{12'd55, 12'd4000, 24'hFEDCBA, 1'b1, 1'b0}},
        // full-length axis lines, crossing the coordinate wrap
        '{'{12'd4090, 12'd17, 8'sd64, 8'sd0, 24'h000000, 24'hFFFFFF}, 1'b0, '0},
        '{'{12'd5, 12'd17, -8'sd64, 8'sd0, 24'hFFFFFF, 24'h000000}, 1'b0, '0},
        '{'{12'd300, 12'd4060, 8'sd0, 8'sd64, 24'hFF00FF, 24'h00FF00}, 1'b0, '0},
        '{'{12'd300, 12'd20, 8'sd0, -8'sd64, 24'h0000FF, 24'hFF0000}, 1'b0, '0},
        // diagonals at exactly the span limit
        '{'{12'd4080, 12'd4080, 8'sd32, 8'sd32, 24'h000000, 24'hFFFFFF}, 1'b0, '0},
        '{'{12'd10, 12'd10, -8'sd32, -8'sd32, 24'hFFFFFF, 24'h000000}, 1'b0, '0},
        // shortest diagonals in every quadrant
        '{'{12'd500, 12'd500, 8'sd1, 8'sd1, 24'h102030, 24'hF0E0D0}, 1'b0, '0},
        '{'{12'd500, 12'd500, 8'sd1, -8'sd1, 24'hF0E0D0, 24'h102030}, 1'b0, '0},
        '{'{12'd500, 12'd500, -8'sd1, 8'sd1, 24'h00FF00, 24'hFF0000}, 1'b0, '0},
        '{'{12'd500, 12'd500, -8'sd1, -8'sd1, 24'h0000FF, 24'h00FF00}, 1'b0, '0},
        // steep and shallow extremes, odd and even |dx| for the rounding of the error start
        '{'{12'd900, 12'd100, -8'sd1, 8'sd63, 24'hFF8000, 24'h0080FF}, 1'b0, '0},
        '{'{12'd900, 12'd100, 8'sd63, 8'sd1, 24'h0080FF, 24'hFF8000}, 1'b0, '0},
        '{'{12'd77, 12'd3, -8'sd5, 8'sd3, 24'hC0FFEE, 24'h123456}, 1'b0, '0},
        '{'{12'd2, 12'd4093, 8'sd4, -8'sd7, 24'h000001, 24'hFFFFFE}, 1'b0, '0},
        // equal colours keep the gradient flat
        '{'{12'd1, 12'd1, -8'sd9, 8'sd6, 24'h5A5A5A, 24'h5A5A5A}, 1'b0, '0}
    };

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Linear blend of one 8-bit channel, quotient truncated toward zero.
    function automatic logic [CHAN_W-1:0] blend_channel(int a, int b, int k, int n);
        int diff;
        int mag;
        int q;
        diff = b - a;
        mag  = (diff < 0) ? -diff : diff;
        q    = (n > 0) ? (mag * k) / n : 0;
        return CHAN_W'((diff < 0) ? a - q : a + q);
    endfunction

    function automatic pixel_word_t gradient_pixel(int x, int y, logic [COLOR_W-1:0] c1,
                                                   logic [COLOR_W-1:0] c2, int k, int n);
        pixel_word_t p;
        p.pixel_x     = COORD_W'(x);
        p.pixel_y     = COORD_W'(y);
        p.pixel_color = {blend_channel(int'(c1[23:16]), int'(c2[23:16]), k, n),
                         blend_channel(int'(c1[15:8]),  int'(c2[15:8]),  k, n),
                         blend_channel(int'(c1[7:0]),   int'(c2[7:0]),   k, n)};
        p.last        = 1'b0;
        p.span_error  = 1'b0;
        return p;
    endfunction

    // Walk one line and queue the pixels it must produce, in drawing order.
    function automatic void predict_line_pixels(line_cmd_t c);
        int          x;
        int          y;
        int          sx;
        int          sy;
        int          adx;
        int          ady;
        int          n;
        int          err;
        int          k;
        int          i;
        pixel_word_t p;
        pixel_word_t line_q[$];
        x   = int'(c.start_x);
        y   = int'(c.start_y);
        sx  = (c.delta_x < 0) ? -1 : 1;
        sy  = (c.delta_y < 0) ? -1 : 1;
        adx = (c.delta_x < 0) ? -int'(c.delta_x) : int'(c.delta_x);
        ady = (c.delta_y < 0) ? -int'(c.delta_y) : int'(c.delta_y);
        err = 0;
        k   = 0;

        // Reject long spans with one zeroed word.
        if (adx + ady > DEFAULT_MAX_SPAN)
        begin
            p = '{'0, '0, '0, 1'b1, 1'b1};
            pending_pixels.push_back(p);
            return;
        end

        if (adx == 0 && ady == 0)
        begin
            p = '{c.start_x, c.start_y, c.color_start, 1'b1, 1'b0};
            pending_pixels.push_back(p);
            return;
        end

        if (ady == 0)
        begin
            n = adx;
            for (k = 0; k < adx && line_q.size() < RESULT_CAP; k++)
            begin
                line_q.push_back(gradient_pixel(x, y, c.color_start, c.color_end, k, n));
                x += sx;
            end
        end
        else if (adx == 0)
        begin
            n = ady;
            for (k = 0; k < ady && line_q.size() < RESULT_CAP; k++)
            begin
                line_q.push_back(gradient_pixel(x, y, c.color_start, c.color_end, k, n));
                y += sy;
            end
        end
        else
        begin
            // x-driven walk; the error starts at -|dx| shifted right arithmetically
            n   = adx + ady;
            err = (-adx) >>> 1;
            for (i = 0; i < adx && line_q.size() < RESULT_CAP; i++)
            begin
                line_q.push_back(gradient_pixel(x, y, c.color_start, c.color_end, k, n));
                k++;
                err += ady;
                while (err > 0 && line_q.size() < RESULT_CAP)
                begin
                    line_q.push_back(gradient_pixel(x, y, c.color_start, c.color_end, k, n));
                    k++;
                    err -= adx;
                    y += sy;
                end
                x += sx;
            end
        end

        line_q[line_q.size() - 1].last = 1'b1;
        foreach (line_q[j])
            pending_pixels.push_back(line_q[j]);
    endfunction

    // Present one command and hold it until the block takes it. Called at a rising edge;
    // returns at the edge where the word was accepted.
    task automatic send_line(line_cmd_t c, logic typed, pixel_word_t want);
        in_valid    <= 1'b1;
        start_x     <= c.start_x;
        start_y     <= c.start_y;
        delta_x     <= c.delta_x;
        delta_y     <= c.delta_y;
        color_start <= c.color_start;
        color_end   <= c.color_end;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (typed)
            pending_pixels.push_back(want);
        else
            predict_line_pixels(c);
    endtask

    // Count down the current burst; at its end drop valid for a random gap.
    task automatic pause_sender();
        int gap;
        burst_left--;
        if (burst_left <= 0)
        begin
            case ($urandom_range(0, 9)) inside
                [0:2]:   gap = 0;
                9:       gap = $urandom_range(100, 400);
                default: gap = $urandom_range(1, 30);
            endcase
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 8);
        end
    endtask

    function automatic logic signed [DELTA_W-1:0] signed_delta(int mag);
        return DELTA_W'($urandom_range(0, 1) ? -mag : mag);
    endfunction

    function automatic line_cmd_t random_line();
        line_cmd_t c;
        int        adx;
        int        ady;
        int        pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            // short line, with axis-aligned and zero-length cases falling out naturally
            adx = $urandom_range(0, 8);
            ady = $urandom_range(0, 8);
            c.delta_x = signed_delta(adx);
            c.delta_y = signed_delta(ady);
        end
        else if (pick < 80)
        begin
            adx = $urandom_range(0, DEFAULT_MAX_SPAN);
            ady = $urandom_range(0, DEFAULT_MAX_SPAN - adx);
            c.delta_x = signed_delta(adx);
            c.delta_y = signed_delta(ady);
        end
        else if (pick < 90)
        begin
            adx = $urandom_range(1, DEFAULT_MAX_SPAN);
            if ($urandom_range(0, 1))
            begin
                c.delta_x = signed_delta(adx);
                c.delta_y = '0;
            end
            else
            begin
                c.delta_x = '0;
                c.delta_y = signed_delta(adx);
            end
        end
        else
        begin
            // raw 8-bit deltas, mostly rejected spans
            c.delta_x = DELTA_W'($urandom());
            c.delta_y = DELTA_W'($urandom());
        end

        case ($urandom_range(0, 5))
            0:       c.start_x = COORD_W'($urandom_range(4032, 4095));
            1:       c.start_x = COORD_W'($urandom_range(0, 63));
            default: c.start_x = COORD_W'($urandom());
        endcase
        case ($urandom_range(0, 5))
            0:       c.start_y = COORD_W'($urandom_range(4032, 4095));
            1:       c.start_y = COORD_W'($urandom_range(0, 63));
            default: c.start_y = COORD_W'($urandom());
        endcase

        c.color_start = COLOR_W'($urandom());
        case ($urandom_range(0, 7))
            0:       c.color_end = c.color_start;
            1:       c.color_end = ~c.color_start;
            2:       c.color_end = '0;
            3:       c.color_end = '1;
            default: c.color_end = COLOR_W'($urandom());
        endcase
        return c;
    endfunction

    // Stimulus: reset, directed table, random commands, then drain and report.
    initial
    begin
        line_cmd_t cmd;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            send_line(directed_rows[r].cmd, directed_rows[r].typed, directed_rows[r].want);
            pause_sender();
        end

        for (int i = 0; i < RANDOM_LINES; i++)
        begin
            cmd = random_line();
            send_line(cmd, 1'b0, '0);
            pause_sender();
        end
        in_valid <= 1'b0;

        // Wait for every owed pixel, then hold on a while to catch stray words.
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_pixels.size() != 0)
            report_mismatch("pixels left pending", 32'(pending_pixels.size()), 0);

        if (mismatch_count == 0)
            $display("gradient_line_rasterizer test passed");
        else
            $display("gradient_line_rasterizer test failed");
        $finish;
    end

    // Receiver stall pattern: switch among free-running, light random, heavy random,
    // periodic and long-block modes, each held for a random span.
    int stall_mode = 0;
    int stall_span = 0;
    int stall_phase = 0;
    int stall_block = 0;

    always @(posedge clk)
    begin
        if (stall_span <= 0)
        begin
            stall_mode = $urandom_range(0, 4);
            stall_span = $urandom_range(64, 512);
        end
        stall_span--;
        stall_phase++;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 2) == 0);
            2: out_stall <= ($urandom_range(0, 3) != 0);
            3: out_stall <= ((stall_phase % 7) < 3);
            default:
            begin
                // hold stall high for blocks of random length, releasing it when a draw is not positive
                if (stall_block <= 0)
                    stall_block = int'($urandom_range(0, 108)) - 8;
                out_stall <= (stall_block > 0);
                stall_block--;
            end
        endcase
    end

    // Check every accepted output word against the oldest owed pixel.
    always @(posedge clk)
    begin
        pixel_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_pixels.size() == 0)
                report_mismatch("word with nothing pending, pixel_x", 32'(pixel_x), 0);
            else
            begin
                want = pending_pixels.pop_front();
                if (pixel_x !== want.pixel_x)
                    report_mismatch("pixel_x", 32'(pixel_x), 32'(want.pixel_x));
                if (pixel_y !== want.pixel_y)
                    report_mismatch("pixel_y", 32'(pixel_y), 32'(want.pixel_y));
                if (pixel_color !== want.pixel_color)
                    report_mismatch("pixel_color", 32'(pixel_color), 32'(want.pixel_color));
                if (last !== want.last)
                    report_mismatch("last", 32'(last), 32'(want.last));
                if (span_error !== want.span_error)
                    report_mismatch("span_error", 32'(span_error), 32'(want.span_error));
            end
        end
    end

    // Stop a hung run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t ns: timeout, %0d pixels pending", $time, pending_pixels.size());
            $display("gradient_line_rasterizer test failed");
            $finish;
        end
    end

endmodule

`default_nettype wire
